// File: rtl/pia_pkg.sv
// ----------------------------------------------------------------------------
// pia_pkg: shared types and constants
// Item layouts, event and register-select codes and control-bit positions for
// the parallel port interface adapter.
// ----------------------------------------------------------------------------
package pia_pkg;

    typedef enum logic [1:0] {
        ACT_RESET   = 2'd0,
        ACT_RISE    = 2'd1,
        ACT_FALL    = 2'd2,
        ACT_UNUSED  = 2'd3
    } pia_action_t;

    typedef enum logic [1:0] {
        RS_PORT_A   = 2'd0,
        RS_CTRL_A   = 2'd1,
        RS_PORT_B   = 2'd2,
        RS_CTRL_B   = 2'd3
    } pia_rs_t;

    // control register bit positions
    localparam int CR_IRQ1_EN   = 0;
    localparam int CR_CL1_RISE  = 1;
    localparam int CR_OUT_SEL   = 2;
    localparam int CR_B3        = 3;
    localparam int CR_B4        = 4;
    localparam int CR_CL2_OUT   = 5;
    localparam int CR_IRQ2_FLAG = 6;
    localparam int CR_IRQ1_FLAG = 7;

    localparam logic [7:0] CR_KEEP_MASK  = 8'b1100_0000;
    localparam logic [7:0] CR_WRITE_MASK = 8'b0011_1111;

    typedef struct packed {
        logic [1:0] action;
        logic       chip_selected;
        logic       read_not_write;
        logic [1:0] reg_select;
        logic [7:0] write_data;
        logic [7:0] port_a_pins;
        logic [7:0] port_b_pins;
        logic       ca1_level;
        logic       ca2_level;
        logic       cb1_level;
        logic       cb2_level;
    } pia_in_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       drive_bus;
        logic       irq_a_n;
        logic       irq_b_n;
        logic       ca2_out;
        logic       ca2_drive;
        logic       cb2_out;
        logic       cb2_drive;
        logic [7:0] port_a_value;
        logic [7:0] port_a_dir;
        logic [7:0] port_b_value;
        logic [7:0] port_b_dir;
    } pia_out_t;

    // per-port event decoded from one input item
    typedef struct packed {
        logic       clear;
        logic       falling;
        logic       ctrl_wr;
        logic [7:0] wr_data;
        logic       port_rd;
        logic       strobe;
        logic       l1;
        logic       l2;
        logic       p1;
        logic       p2;
    } pia_evt_t;

    // per-port state
    typedef struct packed {
        logic [7:0] ctrl;
        logic       level;
        logic       irq_n;
    } pia_side_t;

endpackage

// File: rtl/parallel_port_interface_adapter.sv
// ----------------------------------------------------------------------------
// parallel_port_interface_adapter: two-port peripheral interface adapter
// Each item is one bus event (reset, enable rise, enable fall); each item
// yields one result with bus data, IRQ lines, CA2/CB2 and port registers.
// ----------------------------------------------------------------------------
//  channel  | signals                               | payload
//  ---------+---------------------------------------+------------------
//  input    | in_valid, in_ready, in_data           | pia_pkg::pia_in_t
//  output   | out_valid, out_ready, out_data        | pia_pkg::pia_out_t
//
//  One item per cycle while no result waits with out_ready low: state and
//  the result register update at the accept edge, the result shows after it.
//  The single result register sets the rate; it refills in the cycle it is
//  taken, so in_ready drops only while a result waits with out_ready low.
//  rst_n clears the adapter state and the result valid flag; the control
//  registers and IRQ lines also follow the reset event of the item stream.
// ----------------------------------------------------------------------------
module parallel_port_interface_adapter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pia_pkg::pia_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output pia_pkg::pia_out_t  out_data
);

    logic [7:0] out_a_reg, out_a_next;
    logic [7:0] dir_a_reg, dir_a_next;
    logic [7:0] out_b_reg, out_b_next;
    logic [7:0] dir_b_reg, dir_b_next;
    logic [3:0] prev_reg, prev_next;
    pia_pkg::pia_side_t side_a_reg, side_a_next;
    pia_pkg::pia_side_t side_b_reg, side_b_next;
    pia_pkg::pia_out_t  res_reg, res_next;
    logic               valid_reg;

    pia_pkg::pia_evt_t evt_a;
    pia_pkg::pia_evt_t evt_b;
    logic       accept;
    logic       is_rise;
    logic       is_fall;
    logic       is_clear;
    logic       rd_acc;
    logic       wr_acc;
    logic       rd_a;
    logic       rd_b;
    logic       wr_b;
    logic [7:0] rdata;

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = res_reg;

    assign is_clear = (in_data.action == pia_pkg::ACT_RESET);
    assign is_rise  = (in_data.action == pia_pkg::ACT_RISE);
    assign is_fall  = (in_data.action == pia_pkg::ACT_FALL);
    assign rd_acc   = (is_rise || is_fall) && in_data.chip_selected && in_data.read_not_write;
    assign wr_acc   = is_fall && in_data.chip_selected && !in_data.read_not_write;

    // register read from the state before this item
    always_comb
    begin
        rdata = 8'h00;
        rd_a  = 1'b0;
        rd_b  = 1'b0;
        unique case (pia_pkg::pia_rs_t'(in_data.reg_select))
            pia_pkg::RS_PORT_A:
            begin
                if (side_a_reg.ctrl[pia_pkg::CR_OUT_SEL])
                begin
                    rdata = in_data.port_a_pins;
                    rd_a  = 1'b1;
                end
                else
                begin
                    rdata = dir_a_reg;
                end
            end
            pia_pkg::RS_CTRL_A: rdata = side_a_reg.ctrl;
            pia_pkg::RS_PORT_B:
            begin
                if (side_b_reg.ctrl[pia_pkg::CR_OUT_SEL])
                begin
                    rdata = in_data.port_b_pins;
                    rd_b  = 1'b1;
                end
                else
                begin
                    rdata = dir_b_reg;
                end
            end
            pia_pkg::RS_CTRL_B: rdata = side_b_reg.ctrl;
            default:            rdata = 8'h00;
        endcase
    end

    assign wr_b = wr_acc && (in_data.reg_select == pia_pkg::RS_PORT_B) &&
                  side_b_reg.ctrl[pia_pkg::CR_OUT_SEL];

    always_comb
    begin
        evt_a.clear   = is_clear;
        evt_a.falling = is_fall;
        evt_a.ctrl_wr = wr_acc && (in_data.reg_select == pia_pkg::RS_CTRL_A);
        evt_a.wr_data = in_data.write_data;
        evt_a.port_rd = is_fall && rd_acc && rd_a;
        evt_a.strobe  = is_fall && rd_acc && rd_a;
        evt_a.l1      = in_data.ca1_level;
        evt_a.l2      = in_data.ca2_level;
        evt_a.p1      = prev_reg[0];
        evt_a.p2      = prev_reg[1];

        evt_b.clear   = is_clear;
        evt_b.falling = is_fall;
        evt_b.ctrl_wr = wr_acc && (in_data.reg_select == pia_pkg::RS_CTRL_B);
        evt_b.wr_data = in_data.write_data;
        evt_b.port_rd = is_fall && rd_acc && rd_b;
        evt_b.strobe  = wr_b;
        evt_b.l1      = in_data.cb1_level;
        evt_b.l2      = in_data.cb2_level;
        evt_b.p1      = prev_reg[2];
        evt_b.p2      = prev_reg[3];
    end

    pia_side u_side_a (
        .cur (side_a_reg),
        .evt (evt_a),
        .nxt (side_a_next)
    );

    pia_side u_side_b (
        .cur (side_b_reg),
        .evt (evt_b),
        .nxt (side_b_next)
    );

    always_comb
    begin
        out_a_next = out_a_reg;
        dir_a_next = dir_a_reg;
        out_b_next = out_b_reg;
        dir_b_next = dir_b_reg;
        prev_next  = prev_reg;
        if (is_clear)
        begin
            out_a_next = 8'h00;
            dir_a_next = 8'h00;
            out_b_next = 8'h00;
            dir_b_next = 8'h00;
        end
        else if (is_fall)
        begin
            prev_next = {in_data.cb2_level, in_data.cb1_level,
                         in_data.ca2_level, in_data.ca1_level};
            if (wr_acc && (in_data.reg_select == pia_pkg::RS_PORT_A))
            begin
                if (side_a_reg.ctrl[pia_pkg::CR_OUT_SEL])
                begin
                    out_a_next = in_data.write_data;
                end
                else
                begin
                    dir_a_next = in_data.write_data;
                end
            end
            if (wr_acc && (in_data.reg_select == pia_pkg::RS_PORT_B))
            begin
                if (side_b_reg.ctrl[pia_pkg::CR_OUT_SEL])
                begin
                    out_b_next = in_data.write_data;
                end
                else
                begin
                    dir_b_next = in_data.write_data;
                end
            end
        end
    end

    always_comb
    begin
        res_next.read_data    = rd_acc ? rdata : 8'h00;
        res_next.drive_bus    = rd_acc;
        res_next.irq_a_n      = side_a_next.irq_n;
        res_next.irq_b_n      = side_b_next.irq_n;
        res_next.ca2_drive    = side_a_next.ctrl[pia_pkg::CR_CL2_OUT];
        res_next.ca2_out      = side_a_next.ctrl[pia_pkg::CR_CL2_OUT] && side_a_next.level;
        res_next.cb2_drive    = side_b_next.ctrl[pia_pkg::CR_CL2_OUT];
        res_next.cb2_out      = side_b_next.ctrl[pia_pkg::CR_CL2_OUT] && side_b_next.level;
        res_next.port_a_value = out_a_next;
        res_next.port_a_dir   = dir_a_next;
        res_next.port_b_value = out_b_next;
        res_next.port_b_dir   = dir_b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_a_reg        <= 8'h00;
            dir_a_reg        <= 8'h00;
            out_b_reg        <= 8'h00;
            dir_b_reg        <= 8'h00;
            prev_reg         <= 4'h0;
            side_a_reg.ctrl  <= 8'h00;
            side_a_reg.level <= 1'b0;
            side_a_reg.irq_n <= 1'b1;
            side_b_reg.ctrl  <= 8'h00;
            side_b_reg.level <= 1'b0;
            side_b_reg.irq_n <= 1'b1;
            valid_reg        <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                out_a_reg  <= out_a_next;
                dir_a_reg  <= dir_a_next;
                out_b_reg  <= out_b_next;
                dir_b_reg  <= dir_b_next;
                prev_reg   <= prev_next;
                side_a_reg <= side_a_next;
                side_b_reg <= side_b_next;
                valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    a_bus_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.drive_bus) |-> (out_data.read_data == 8'h00))
        else $error("read_data not zero while bus is not driven");

    a_cl2_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.ca2_drive || !out_data.ca2_out) &&
                       (out_data.cb2_drive || !out_data.cb2_out)))
        else $error("CL2 level shown while not in output mode");

    a_reset_evt: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_clear) |=> ((side_a_reg.ctrl == 8'h00) &&
                                  (side_b_reg.ctrl == 8'h00) &&
                                  side_a_reg.irq_n && side_b_reg.irq_n))
        else $error("reset item did not clear control state");

    a_irq2_out_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (!(side_a_reg.ctrl[pia_pkg::CR_CL2_OUT] && side_a_reg.ctrl[pia_pkg::CR_IRQ2_FLAG]) &&
         !(side_b_reg.ctrl[pia_pkg::CR_CL2_OUT] && side_b_reg.ctrl[pia_pkg::CR_IRQ2_FLAG])))
        else $error("IRQ2 flag set while CL2 is an output");

endmodule

// File: rtl/pia_side.sv
// ----------------------------------------------------------------------------
// pia_side: control logic of one port
// Control write, CL1/CL2 edge detection, IRQ flags, IRQ line and CL2 output.
// ----------------------------------------------------------------------------
module pia_side (
    input  pia_pkg::pia_side_t cur,
    input  pia_pkg::pia_evt_t  evt,
    output pia_pkg::pia_side_t nxt
);

    logic [7:0] c_w;
    logic [7:0] c_f;
    logic       lvl_w;
    logic       lvl_n;
    logic       t1;
    logic       t2;
    logic       irq;

    always_comb
    begin
        c_w = evt.ctrl_wr ? ((cur.ctrl & pia_pkg::CR_KEEP_MASK) |
                             (evt.wr_data & pia_pkg::CR_WRITE_MASK)) : cur.ctrl;
        lvl_w = cur.level;
        // pulse or handshake mode selected: raise CL2 first
        if (evt.ctrl_wr && c_w[pia_pkg::CR_CL2_OUT] && !c_w[pia_pkg::CR_B4])
        begin
            lvl_w = 1'b1;
        end

        t1 = c_w[pia_pkg::CR_CL1_RISE] ? (evt.l1 && !evt.p1) : (!evt.l1 && evt.p1);
        t2 = !c_w[pia_pkg::CR_CL2_OUT] &&
             (c_w[pia_pkg::CR_B4] ? (evt.l2 && !evt.p2) : (!evt.l2 && evt.p2));

        c_f = c_w;
        if (evt.port_rd)
        begin
            c_f[pia_pkg::CR_IRQ1_FLAG] = 1'b0;
            c_f[pia_pkg::CR_IRQ2_FLAG] = 1'b0;
        end
        if (t1)
        begin
            c_f[pia_pkg::CR_IRQ1_FLAG] = 1'b1;
        end
        if (t2)
        begin
            c_f[pia_pkg::CR_IRQ2_FLAG] = 1'b1;
        end
        if (c_f[pia_pkg::CR_CL2_OUT])
        begin
            c_f[pia_pkg::CR_IRQ2_FLAG] = 1'b0;
        end

        if (!c_f[pia_pkg::CR_CL2_OUT])
        begin
            lvl_n = lvl_w;
        end
        else if (c_f[pia_pkg::CR_B4])
        begin
            lvl_n = c_f[pia_pkg::CR_B3];
        end
        else if (evt.strobe)
        begin
            lvl_n = 1'b0;
        end
        else if (c_f[pia_pkg::CR_B3])
        begin
            lvl_n = 1'b1;
        end
        else
        begin
            lvl_n = lvl_w | t1;
        end

        irq = (c_f[pia_pkg::CR_IRQ1_FLAG] && c_f[pia_pkg::CR_IRQ1_EN]) ||
              (c_f[pia_pkg::CR_IRQ2_FLAG] && c_f[pia_pkg::CR_B3]);

        if (evt.clear)
        begin
            nxt.ctrl  = 8'h00;
            nxt.level = cur.level;
            nxt.irq_n = 1'b1;
        end
        else if (evt.falling)
        begin
            nxt.ctrl  = c_f;
            nxt.level = lvl_n;
            nxt.irq_n = !irq;
        end
        else
        begin
            nxt = cur;
        end
    end

endmodule
